// File: hdl/kmcps_pkg.sv
// Package for the k-mismatch class pattern search block.
// Holds request and position codes, controller states and the
// command/status structs. No dependencies.
package kmcps_pkg;

    localparam int REQ_W   = 2;
    localparam int IDX_W   = 6;
    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 64;
    localparam int CNT_W   = 7;
    localparam int OPOS_W  = 16;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 7;
    localparam logic [CNT_W-1:0] CNT_SAT = 7'd127;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_TEXT = 2'd1,
        REQ_EOT  = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_LIT   = 2'd0,
        KIND_ANY   = 2'd1,
        KIND_CLASS = 2'd2,
        KIND_NEG   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_LIMIT  = 2'd0,
        CFG_ASTART = 2'd1,
        CFG_AEND   = 2'd2,
        CFG_LEN    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [IDX_W-1:0]   load_index;
        logic [1:0]         position_kind;
        logic [CHAR_W-1:0]  literal_char;
        logic [CLASS_W-1:0] class_low;
        logic [CLASS_W-1:0] class_high;
        logic [CHAR_W-1:0]  text_char;
    } t_in_item;

    typedef struct packed {
        logic load;        // write one pattern position
        logic byte_start;  // latch a text byte, start the slot sweep
        logic issue;       // read one alignment slot
        logic finish;      // close the byte: position, slot, hit
        logic eot;         // end of text: evaluate and clear the search
        logic emit;        // move the pending result to the output
    } t_cmd;

    typedef struct packed {
        logic done;      // a match was already reported
        logic k_last;    // sweep is at its last slot
        logic hit;       // this byte completed an alignment, not end-anchored
        logic out_busy;  // output holds an item not yet taken
    } t_status;

endpackage

// File: hdl/kmcps_if.sv
// Channel interfaces for the pattern search: input items, result items
// and configuration writes. Depends on kmcps_pkg.
interface kmcps_in_if;
    logic                           valid;
    logic                           ready;
    logic [kmcps_pkg::REQ_W-1:0]    req_type;
    logic [kmcps_pkg::IDX_W-1:0]    load_index;
    logic [1:0]                     position_kind;
    logic [kmcps_pkg::CHAR_W-1:0]   literal_char;
    logic [kmcps_pkg::CLASS_W-1:0]  class_low;
    logic [kmcps_pkg::CLASS_W-1:0]  class_high;
    logic [kmcps_pkg::CHAR_W-1:0]   text_char;
    modport source (output valid, req_type, load_index, position_kind, literal_char,
                    class_low, class_high, text_char, input ready);
    modport sink (input valid, req_type, load_index, position_kind, literal_char,
                  class_low, class_high, text_char, output ready);
endinterface

interface kmcps_out_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [kmcps_pkg::OPOS_W-1:0]   match_start;
    logic [kmcps_pkg::OPOS_W-1:0]   match_end;
    logic [kmcps_pkg::CNT_W-1:0]    mismatches;
    modport source (output valid, found, match_start, match_end, mismatches,
                    input ready);
    modport sink (input valid, found, match_start, match_end, mismatches,
                  output ready);
endinterface

interface kmcps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kmcps_pkg::CFGI_W-1:0]   index;
    logic [kmcps_pkg::CFGD_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/kmcps_ctrl.sv
// Controller state machine of the pattern search.
// Depends on kmcps_pkg; drives commands to kmcps_datapath.
module kmcps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_req_type,
    input  kmcps_pkg::t_status  i_stat,
    output logic                o_in_ready,
    output kmcps_pkg::t_cmd     o_cmd,
    output kmcps_pkg::t_state   o_state
);
    import kmcps_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_take;

    assign w_take  = i_in_valid && (r_state == ST_IDLE);
    assign o_state = r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && i_req_type == REQ_TEXT && !i_stat.done) begin
                    n_state = ST_SCAN;
                end else if (w_take && i_req_type == REQ_EOT && !i_stat.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (i_stat.k_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_FIN;
            ST_FIN:   n_state = i_stat.hit ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (!i_stat.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load      = w_take && i_req_type == REQ_LOAD;
                o_cmd.byte_start = w_take && i_req_type == REQ_TEXT && !i_stat.done;
                o_cmd.eot       = w_take && i_req_type == REQ_EOT;
            end
            ST_SCAN:  o_cmd.issue  = 1'b1;
            ST_DRAIN: o_cmd        = '0;
            ST_FIN:   o_cmd.finish = 1'b1;
            ST_EMIT:  o_cmd.emit   = !i_stat.out_busy;
            default:  o_cmd        = '0;
        endcase
    end

endmodule

// File: hdl/kmcps_datapath.sv
// Datapath of the pattern search: pattern memories, per-slot alignment
// state, the slot sweep pipeline and the result registers.
// Depends on kmcps_pkg and kmcps_if.
module kmcps_datapath #(
    parameter int MAX_PATTERN   = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kmcps_pkg::t_in_item  i_item,
    input  kmcps_pkg::t_cmd      i_cmd,
    output kmcps_pkg::t_status   o_stat,
    kmcps_cfg_if.sink            cfg,
    kmcps_out_if.source          res
);
    import kmcps_pkg::*;

    localparam int SLOT_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW     = 10;  // width for length/offset compares
    localparam int WW     = POSITION_BITS + 10;
    localparam logic [CW-1:0] MAXP = CW'(MAX_PATTERN);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // configuration
    logic [CNT_W-1:0]  r_limit;
    logic              r_astart;
    logic              r_aend;
    logic [CFGD_W-1:0] r_len_cfg;

    // memories
    logic [9:0]           m_kc  [MAX_PATTERN];
    logic [2*CLASS_W-1:0] m_cls [MAX_PATTERN];
    logic [CNT_W-1:0]     m_cnt [MAX_PATTERN];

    // search state
    logic [MAX_PATTERN-1:0]   r_alive;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_done;
    logic [SLOT_W-1:0]        r_slot;
    logic                     r_cand_v;
    logic [CNT_W-1:0]         r_cand_mm;
    logic [CHAR_W-1:0]        r_char;
    logic                     r_start;
    logic [CW-1:0]            r_len;
    logic                     r_hit;
    logic [CNT_W-1:0]         r_hit_mm;

    // sweep pipeline
    logic [SLOT_W-1:0]    r_k;
    logic                 r_v2;
    logic [SLOT_W-1:0]    r_k2;
    logic [CW-1:0]        r_off2;
    logic [9:0]           r_kc;
    logic [2*CLASS_W-1:0] r_cls;
    logic [CNT_W-1:0]     r_cnt;

    // pending and output result
    logic              r_p_found;
    logic [OPOS_W-1:0] r_p_start;
    logic [OPOS_W-1:0] r_p_end;
    logic [CNT_W-1:0]  r_p_mm;
    logic              r_o_valid;
    logic              r_o_found;
    logic [OPOS_W-1:0] r_o_start;
    logic [OPOS_W-1:0] r_o_end;
    logic [CNT_W-1:0]  r_o_mm;

    logic [CW-1:0]     w_len_eff;
    logic [CW-1:0]     w_lidx;
    logic [SLOT_W-1:0] w_off;
    logic              w_fresh;
    logic              w_alive_in;
    logic [CNT_W-1:0]  w_cnt_in;
    logic [CNT_W-1:0]  w_cnt_new;
    logic              w_member;
    logic              w_mism;
    logic              w_alive_new;
    logic              w_complete;
    logic [WW-1:0]     w_pos_x;
    logic [WW-1:0]     w_len_x;
    logic [WW-1:0]     w_s_hit;
    logic [WW-1:0]     w_e_hit;
    logic [WW-1:0]     w_s_eot;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= '0;
            r_astart  <= 1'b0;
            r_aend    <= 1'b0;
            r_len_cfg <= CFGD_W'(1);
        end else if (cfg.valid) begin
            unique case (t_cfg_idx'(cfg.index))
                CFG_LIMIT:  r_limit   <= cfg.data;
                CFG_ASTART: r_astart  <= cfg.data[0];
                CFG_AEND:   r_aend    <= cfg.data[0];
                CFG_LEN:    r_len_cfg <= cfg.data;
                default:    r_limit   <= r_limit;
            endcase
        end
    end

    always_comb begin
        w_len_eff = CW'(r_len_cfg);
        if (w_len_eff == '0) begin
            w_len_eff = CW'(1);
        end else if (w_len_eff > MAXP) begin
            w_len_eff = MAXP;
        end
    end

    // pattern load
    assign w_lidx = CW'(i_item.load_index);
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_lidx < MAXP) begin
            m_kc[SLOT_W'(i_item.load_index)]  <= {i_item.position_kind, i_item.literal_char};
            m_cls[SLOT_W'(i_item.load_index)] <= {i_item.class_high, i_item.class_low};
        end
    end

    // pattern offset of slot r_k relative to the current slot
    assign w_off = (r_slot >= r_k) ? (r_slot - r_k)
                 : SLOT_W'(CW'(r_slot) + MAXP - CW'(r_k));

    always_ff @(posedge i_clk) begin
        r_kc  <= m_kc[w_off];
        r_cls <= m_cls[w_off];
        r_cnt <= m_cnt[r_k];
        r_k2  <= r_k;
        r_off2 <= CW'(w_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_k  <= '0;
        end else begin
            r_v2 <= i_cmd.issue;
            if (i_cmd.byte_start) begin
                r_k <= '0;
            end else if (i_cmd.issue && !o_stat.k_last) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // second stage: test one alignment against the byte
    assign w_fresh    = r_start && (r_k2 == r_slot);
    assign w_alive_in = w_fresh || r_alive[r_k2];
    assign w_cnt_in   = w_fresh ? '0 : r_cnt;

    always_comb begin
        if (r_char[7]) begin
            w_member = 1'b0;
        end else if (r_char[6]) begin
            w_member = r_cls[CLASS_W + int'(r_char[5:0])];
        end else begin
            w_member = r_cls[int'(r_char[5:0])];
        end
        unique case (t_kind'(r_kc[9:8]))
            KIND_LIT:   w_mism = r_char != r_kc[7:0];
            KIND_ANY:   w_mism = 1'b0;
            KIND_CLASS: w_mism = !w_member;
            KIND_NEG:   w_mism = w_member;
            default:    w_mism = 1'b0;
        endcase
    end

    always_comb begin
        w_cnt_new   = w_cnt_in;
        w_alive_new = w_alive_in;
        w_complete  = 1'b0;
        if (w_alive_in) begin
            if (r_off2 >= r_len) begin
                w_alive_new = 1'b0;
            end else begin
                if (w_mism) begin
                    if (w_cnt_in < CNT_SAT) begin
                        w_cnt_new = w_cnt_in + 1'b1;
                    end
                    if (w_cnt_new > r_limit) begin
                        w_alive_new = 1'b0;
                    end
                end
                if (w_alive_new && r_off2 == r_len - 1'b1) begin
                    w_alive_new = 1'b0;
                    w_complete  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            m_cnt[r_k2] <= w_cnt_new;
        end
    end

    // result positions
    assign w_pos_x = WW'(r_pos);
    assign w_len_x = WW'(r_len);
    assign w_s_hit = (w_pos_x >= w_len_x - 1'b1) ? w_pos_x - (w_len_x - 1'b1) : '0;
    assign w_e_hit = (r_pos < POS_MAX) ? w_pos_x + 1'b1 : WW'(POS_MAX);
    assign w_s_eot = (w_pos_x >= WW'(w_len_eff)) ? w_pos_x - WW'(w_len_eff) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive  <= '0;
            r_pos    <= '0;
            r_done   <= 1'b0;
            r_slot   <= '0;
            r_cand_v <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            if (i_cmd.byte_start) begin
                r_char   <= i_item.text_char;
                r_start  <= !r_astart || r_pos == '0;
                r_len    <= w_len_eff;
                r_cand_v <= 1'b0;
                r_hit    <= 1'b0;
            end
            if (r_v2) begin
                r_alive[r_k2] <= w_alive_new;
                if (w_complete && r_aend) begin
                    r_cand_v  <= 1'b1;
                    r_cand_mm <= w_cnt_new;
                end else if (w_complete) begin
                    r_hit    <= 1'b1;
                    r_hit_mm <= w_cnt_new;
                end
            end
            if (i_cmd.finish) begin
                r_slot <= (CW'(r_slot) == MAXP - 1'b1) ? '0 : r_slot + 1'b1;
                if (r_pos < POS_MAX) begin
                    r_pos <= r_pos + 1'b1;
                end
                if (r_hit) begin
                    r_done    <= 1'b1;
                    r_p_found <= 1'b1;
                    r_p_start <= w_s_hit[OPOS_W-1:0];
                    r_p_end   <= w_e_hit[OPOS_W-1:0];
                    r_p_mm    <= r_hit_mm;
                end
            end
            if (i_cmd.eot) begin
                r_p_found <= r_cand_v;
                r_p_start <= r_cand_v ? w_s_eot[OPOS_W-1:0] : '0;
                r_p_end   <= r_cand_v ? w_pos_x[OPOS_W-1:0] : '0;
                r_p_mm    <= r_cand_v ? r_cand_mm : '0;
                r_alive   <= '0;
                r_pos     <= '0;
                r_done    <= 1'b0;
                r_slot    <= '0;
                r_cand_v  <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_found <= r_p_found;
            r_o_start <= r_p_start;
            r_o_end   <= r_p_end;
            r_o_mm    <= r_p_mm;
        end
    end

    assign res.valid       = r_o_valid;
    assign res.found       = r_o_found;
    assign res.match_start = r_o_start;
    assign res.match_end   = r_o_end;
    assign res.mismatches  = r_o_mm;

    assign o_stat.done     = r_done;
    assign o_stat.k_last   = r_k == SLOT_W'(MAX_PATTERN - 1);
    assign o_stat.hit      = r_hit;
    assign o_stat.out_busy = r_o_valid && !res.ready;

endmodule

// File: hdl/k_mismatch_class_pattern_search.sv
// Top level of the k-mismatch class pattern search.
// Depends on kmcps_pkg, kmcps_if, kmcps_ctrl and kmcps_datapath.
//
// The block finds the leftmost alignment of a loaded pattern in a byte
// stream that has at most mismatch_limit mismatching literal or class
// positions. Load items write one pattern position each. A text byte is
// accepted, swept over every alignment slot through a two-stage read/test
// pipeline, drained and closed. The sweep is serial because the per-slot
// mismatch counts live in a memory with one read and one write port. A
// byte that completes a match then moves its result into the output
// register in the emit state, waiting there while that register still
// holds an earlier result that has not been taken. End of text moves its
// result the same way, with the same wait, unless a match was already
// reported. At most one result item leaves per search: the match when one
// completes, or the end-anchored candidate or not-found at end of text.
// The output register lets the next input item be taken while a result
// waits. There is no clearing pass after reset; alignment state is
// qualified by flops.
module k_mismatch_class_pattern_search #(
    parameter int MAX_PATTERN   = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kmcps_in_if.sink      i_in,
    kmcps_cfg_if.sink     i_cfg,
    kmcps_out_if.source   o_out
);
    import kmcps_pkg::*;

    t_cmd     w_cmd;
    t_status  w_stat;
    t_state   w_state;
    t_in_item w_item;
    logic     w_ready;

    assign i_in.ready = w_ready;
    assign w_item = '{req_type: i_in.req_type, load_index: i_in.load_index,
                      position_kind: i_in.position_kind,
                      literal_char: i_in.literal_char, class_low: i_in.class_low,
                      class_high: i_in.class_high, text_char: i_in.text_char};

    kmcps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .i_stat     (w_stat),
        .o_in_ready (w_ready),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    kmcps_datapath #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .cfg     (i_cfg),
        .res     (o_out)
    );

    // A result is never moved into an output slot still holding one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out.valid || o_out.ready))
        else $error("result overwritten before it was taken");

    // A new result only appears after an emit command.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.emit))
        else $error("result appeared without an emit");

    // No input item is taken while the slot sweep runs.
    a_no_take_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> !i_in.ready)
        else $error("input taken during the slot sweep");

    // Sweep ends in drain and then finish.
    a_sweep_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_DRAIN) |=> w_cmd.finish)
        else $error("byte not closed after the sweep");

endmodule
